FILE: hw/rtl/assert_macros.svh
// Assertion macros, included by the instruction counter unit.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every cycle out of reset.
`define ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/bbic_pkg.sv
// Package for the bytecode block instruction counter.
// Field widths, operation and error codes, payload and stack entry types; no dependencies.
`default_nettype none

package bbic_pkg;

   localparam int unsigned TAG_W               = 32;
   localparam int unsigned COUNT_W             = 32;
   localparam int unsigned FUNC_W              = 3;
   localparam int unsigned ERR_W               = 3;
   localparam int unsigned STACK_DEPTH_DEFAULT = 64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_OTHER = 3'd0,
      FUNC_BLOCK = 3'd1,
      FUNC_LOOP  = 3'd2,
      FUNC_IF    = 3'd3,
      FUNC_END   = 3'd4,
      FUNC_CONST = 3'd5
   } func_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_MISSING   = 3'd1,
      ERR_UNKNOWN   = 3'd2,
      ERR_EMPTY_END = 3'd3,
      ERR_OVERFLOW  = 3'd4,
      ERR_NO_PARENT = 3'd5
   } err_type;

   typedef struct packed {
      logic              first_of_function;
      logic [FUNC_W-1:0] func;
      logic [TAG_W-1:0]  instr_tag;
   } req_type;

   typedef struct packed {
      logic               patch_valid;
      logic [TAG_W-1:0]   patch_tag;
      logic [COUNT_W-1:0] patch_value;
      err_type            error_code;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TAG_W-1:0]   tag;
      logic               is_tagged;
   } entry_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bbic_channels.sv
// Valid/ready channel interfaces for operation requests and patch responses.
// Depends on bbic_pkg for field widths.
`default_nettype none

interface bbic_req_if;
   logic                         valid;
   logic                         ready;
   logic                         first_of_function;
   logic [bbic_pkg::FUNC_W-1:0]  func;
   logic [bbic_pkg::TAG_W-1:0]   instr_tag;

   modport source (output valid, output first_of_function, output func, output instr_tag,
                   input ready);
   modport sink   (input valid, input first_of_function, input func, input instr_tag,
                   output ready);
endinterface

interface bbic_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          patch_valid;
   logic [bbic_pkg::TAG_W-1:0]    patch_tag;
   logic [bbic_pkg::COUNT_W-1:0]  patch_value;
   logic [bbic_pkg::ERR_W-1:0]    error_code;

   modport source (output valid, output patch_valid, output patch_tag, output patch_value,
                   output error_code, input ready);
   modport sink   (input valid, input patch_valid, input patch_tag, input patch_value,
                   input error_code, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bbic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbic_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bytecode_block_instruction_counter_unit.sv
// Bytecode block instruction counter: stack of per-block counters producing constant patches.
// Depends on bbic_pkg, bbic_channels (bbic_req_if, bbic_rsp_if), bbic_ram, assert_macros.svh.
//
//   channel   | dir | payload                                    | transfer when
//   ----------+-----+--------------------------------------------+-------------------
//   req_chan  | in  | first_of_function, func, instr_tag         | valid && ready
//   rsp_chan  | out | patch_valid, patch_tag, patch_value,       | valid && ready
//             |     | error_code                                 |
//
// One operation per cycle unless the response stalls; input register, then result register.
// Top two stack entries live in registers; deeper entries sit in a RAM whose next-needed
// entry is prefetched every cycle, with a one-entry bypass for a same-cycle write.
// Synchronous reset empties the stack, sets the expect-constant flag, clears the error.
// A stalled response holds the pipe; the input register accepts when empty or able to drain.
`default_nettype none
`include "assert_macros.svh"

module bytecode_block_instruction_counter_unit #(
   parameter int unsigned STACK_DEPTH = bbic_pkg::STACK_DEPTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   bbic_req_if.sink   req_chan,
   bbic_rsp_if.source rsp_chan
);

   localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
   localparam int unsigned ENT_W  = $bits(bbic_pkg::entry_type);

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   bbic_pkg::req_type s1_ff;
   logic              s1_fire;
   logic              req_xfer;

   // output stage
   logic              rsp_valid_ff, rsp_valid_in;
   bbic_pkg::rsp_type rsp_ff, rsp_in;
   logic              out_free;

   // stack state
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                exp_ff, exp_in;
   bbic_pkg::err_type   err_ff, err_in;
   bbic_pkg::entry_type top_ff, top_in;
   bbic_pkg::entry_type sec_ff, sec_in;
   logic                byp_ff, byp_in;
   bbic_pkg::entry_type byp_data_ff;

   // RAM
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   bbic_pkg::entry_type ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ENT_W-1:0]    ram_rd_data;

   // step working values
   logic [LVL_W-1:0]    lvl;
   logic                expct;
   bbic_pkg::err_type   err;
   bbic_pkg::entry_type top;
   bbic_pkg::entry_type sec;
   bbic_pkg::entry_type below;
   logic                cnt_a, cnt_b, psh, pop, set_exp, psh_tagged;
   logic [bbic_pkg::TAG_W-1:0]   psh_tag;
   logic [bbic_pkg::COUNT_W-1:0] residual;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire     = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_xfer    = req_chan.valid && req_chan.ready;
   assign s1_valid_in = req_xfer || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      lvl        = lvl_ff;
      expct      = exp_ff;
      err        = err_ff;
      top        = top_ff;
      sec        = sec_ff;
      below      = byp_ff ? byp_data_ff : bbic_pkg::entry_type'(ram_rd_data);
      cnt_a      = 1'b0;
      cnt_b      = 1'b0;
      psh        = 1'b0;
      pop        = 1'b0;
      set_exp    = 1'b0;
      psh_tag    = '0;
      psh_tagged = 1'b0;
      residual   = '0;
      wr_en      = 1'b0;
      wr_addr    = ADDR_W'(lvl_ff - LVL_W'(2));
      rsp_in     = '{patch_valid: 1'b0, patch_tag: '0, patch_value: '0,
                     error_code: bbic_pkg::ERR_NONE};

      if (err_ff == bbic_pkg::ERR_NONE) begin
         if (s1_ff.first_of_function) begin
            lvl   = '0;
            expct = 1'b1;
         end
         case (s1_ff.func)
            bbic_pkg::FUNC_OTHER: begin
               cnt_a = 1'b1;
            end
            bbic_pkg::FUNC_BLOCK, bbic_pkg::FUNC_LOOP: begin
               cnt_a   = 1'b1;
               set_exp = 1'b1;
            end
            bbic_pkg::FUNC_IF: begin
               cnt_a = 1'b1;
               psh   = 1'b1;
            end
            bbic_pkg::FUNC_CONST: begin
               psh        = expct;
               psh_tag    = s1_ff.instr_tag;
               psh_tagged = 1'b1;
               cnt_b      = 1'b1;
            end
            bbic_pkg::FUNC_END: begin
               pop = 1'b1;
            end
            default: begin
               err = bbic_pkg::ERR_UNKNOWN;
            end
         endcase

         if (cnt_a) begin
            if (lvl != '0) top.count = top.count + 1'b1;
            if (expct) err = bbic_pkg::ERR_MISSING;
         end
         if (set_exp) expct = 1'b1;

         if (psh && err == bbic_pkg::ERR_NONE) begin
            if (lvl >= LVL_W'(STACK_DEPTH)) begin
               err = bbic_pkg::ERR_OVERFLOW;
            end else begin
               if (lvl >= LVL_W'(2)) begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(lvl - LVL_W'(2));
               end
               sec = top;
               top = '{count: '0, tag: psh_tag, is_tagged: psh_tagged};
               lvl = lvl + 1'b1;
               if (psh_tagged) expct = 1'b0;
            end
         end

         if (cnt_b && err == bbic_pkg::ERR_NONE) begin
            if (lvl != '0) top.count = top.count + 1'b1;
            if (expct) err = bbic_pkg::ERR_MISSING;
         end

         if (pop) begin
            if (lvl == '0) begin
               err = bbic_pkg::ERR_EMPTY_END;
            end else begin
               if (top.is_tagged) begin
                  rsp_in.patch_valid = 1'b1;
                  rsp_in.patch_tag   = top.tag;
                  rsp_in.patch_value = top.count;
               end else begin
                  residual = top.count;
               end
               lvl       = lvl - 1'b1;
               top       = sec;
               top.count = sec.count + residual;
               sec       = below;
               if (residual != '0 && lvl == '0) err = bbic_pkg::ERR_NO_PARENT;
            end
         end
      end
      rsp_in.error_code = err;

      lvl_in = s1_fire ? lvl   : lvl_ff;
      exp_in = s1_fire ? expct : exp_ff;
      err_in = s1_fire ? err   : err_ff;
      top_in = s1_fire ? top   : top_ff;
      sec_in = s1_fire ? sec   : sec_ff;
   end

   assign ram_wr_en   = s1_fire && wr_en;
   assign ram_wr_addr = wr_addr;
   assign ram_wr_data = sec_ff;
   assign ram_rd_addr = ADDR_W'(lvl_in - LVL_W'(3));
   assign byp_in      = ram_wr_en && (ram_wr_addr == ram_rd_addr);

   bbic_ram #(
      .WIDTH (ENT_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
         exp_ff       <= 1'b1;
         err_ff       <= bbic_pkg::ERR_NONE;
         byp_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
         exp_ff       <= exp_in;
         err_ff       <= err_in;
         byp_ff       <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= '{first_of_function: req_chan.first_of_function,
                    func: req_chan.func, instr_tag: req_chan.instr_tag};
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
      top_ff      <= top_in;
      sec_ff      <= sec_in;
      byp_data_ff <= ram_wr_data;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.patch_valid = rsp_ff.patch_valid;
   assign rsp_chan.patch_tag   = rsp_ff.patch_tag;
   assign rsp_chan.patch_value = rsp_ff.patch_value;
   assign rsp_chan.error_code  = rsp_ff.error_code;

   `ASSERT_ALWAYS(a_level_bound, lvl_ff <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
   `ASSERT_NEXT(a_err_sticky, err_ff != bbic_pkg::ERR_NONE, $stable(err_ff), "error not sticky")
   `ASSERT_IMPLIES(a_patch_no_err, rsp_valid_ff && rsp_ff.patch_valid,
                   rsp_ff.error_code == bbic_pkg::ERR_NONE, "patch reported with error")
   `ASSERT_IMPLIES(a_idle_patch_zero, rsp_valid_ff && !rsp_ff.patch_valid,
                   rsp_ff.patch_tag == '0 && rsp_ff.patch_value == '0, "stale patch fields")

endmodule

`default_nettype wire
